### sv/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants for the sparse polynomial adder
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

	// default depth of each term list
	localparam int unsigned TERMS_PER_LIST_DEF = 32;

	localparam int unsigned COEFF_W = 16;
	localparam int unsigned POWER_W = 16;
	localparam int unsigned SUM_W   = COEFF_W + 1;

	// command codes
	localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_ADD         = 2'd2;

	// one input beat
	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [COEFF_W-1:0] term_coeff;
		logic [POWER_W-1:0]        term_power;
	} in_item_t;

	// one result beat
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_coeff;
		logic [POWER_W-1:0]      sum_power;
		logic                    last_term;
		logic                    empty_sum;
		logic                    overflow;
	} out_item_t;

	// one stored term
	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff;
		logic [POWER_W-1:0]        power;
	} term_t;

endpackage

`default_nettype wire

### sv/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// adds two sparse polynomials held as descending-power term lists
// ----------------------------------------------------------------------------
// usage
//   input channel: a beat is taken on a rising edge with start high and busy
//   low. cmd selects load into the first list, load into the second list,
//   or add. cmd code 3 is taken and ignored.
//   a load never raises busy; a load into a full list is
//   dropped and remembered in a sticky overflow flag.
//   an add of non-empty lists raises busy and merges both lists. each merge
//   step is a term-memory read state followed by a compare/add state, which
//   registers that step's result.
//   an add with both lists empty emits one empty result on the next cycle.
//   result channel: each result sits on result for one cycle with result_stb
//   high. the receiver cannot stall, so nothing is held back.
//   the final result of an add has last_term set; after it both lists and
//   the overflow flag are cleared and busy falls.
//   reset clears the list counts, the overflow flag and the sequencer; the
//   term memories keep no reset and are only read below their fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_adder #(
	parameter int unsigned TERMS_PER_LIST = spa_pkg::TERMS_PER_LIST_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire spa_pkg::in_item_t  item,
	output logic                    result_stb,
	output spa_pkg::out_item_t      result
);

	import spa_pkg::*;

	// count width holds the depth itself, address width indexes the memory
	localparam int unsigned CW = $clog2(TERMS_PER_LIST + 1);
	localparam int unsigned AW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;

	logic [1:0] state_q;

	// term memories, one per list
	term_t first_mem [TERMS_PER_LIST];
	term_t second_mem [TERMS_PER_LIST];
	term_t first_rd_q;
	term_t second_rd_q;

	logic [CW-1:0] first_cnt_q;
	logic [CW-1:0] second_cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic          dropped_q;

	out_item_t result_q;
	logic      result_stb_q;

	logic accept;
	logic first_full;
	logic second_full;

	// merge step
	logic                     first_has;
	logic                     second_has;
	logic                     take_first;
	logic                     take_second;
	logic [CW-1:0]            i_next;
	logic [CW-1:0]            j_next;
	logic signed [SUM_W-1:0]  first_ext;
	logic signed [SUM_W-1:0]  second_ext;
	logic signed [SUM_W-1:0]  step_coeff;
	logic [POWER_W-1:0]       step_power;
	logic                     step_last;

	assign accept      = start && !busy;
	assign first_full  = (first_cnt_q == CW'(TERMS_PER_LIST));
	assign second_full = (second_cnt_q == CW'(TERMS_PER_LIST));

	assign busy       = (state_q != ST_IDLE);
	assign result     = result_q;
	assign result_stb = result_stb_q;

	// memory writes during loads, registered reads at the merge indexes
	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_LOAD_FIRST && !first_full) begin
			first_mem[first_cnt_q[AW-1:0]] <= '{coeff: item.term_coeff,
				power: item.term_power};
		end
		if (accept && item.cmd == CMD_LOAD_SECOND && !second_full) begin
			second_mem[second_cnt_q[AW-1:0]] <= '{coeff: item.term_coeff,
				power: item.term_power};
		end
		first_rd_q  <= first_mem[i_q[AW-1:0]];
		second_rd_q <= second_mem[j_q[AW-1:0]];
	end

	// shared compare and add unit
	always_comb begin
		first_has   = (i_q < first_cnt_q);
		second_has  = (j_q < second_cnt_q);
		first_ext   = SUM_W'(first_rd_q.coeff);
		second_ext  = SUM_W'(second_rd_q.coeff);
		take_first  = 1'b0;
		take_second = 1'b0;
		if (first_has && second_has) begin
			if (first_rd_q.power == second_rd_q.power) begin
				take_first  = 1'b1;
				take_second = 1'b1;
			end else if (first_rd_q.power > second_rd_q.power) begin
				take_first = 1'b1;
			end else begin
				take_second = 1'b1;
			end
		end else if (first_has) begin
			take_first = 1'b1;
		end else begin
			take_second = 1'b1;
		end
		step_coeff = (take_first ? first_ext : '0) + (take_second ? second_ext : '0);
		step_power = take_first ? first_rd_q.power : second_rd_q.power;
		i_next     = take_first ? i_q + CW'(1) : i_q;
		j_next     = take_second ? j_q + CW'(1) : j_q;
		step_last  = (i_next == first_cnt_q) && (j_next == second_cnt_q);
	end

	// sequencer, counts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			dropped_q    <= 1'b0;
			result_stb_q <= 1'b0;
		end else begin
			result_stb_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.cmd)
							CMD_LOAD_FIRST: begin
								if (first_full) begin
									dropped_q <= 1'b1;
								end else begin
									first_cnt_q <= first_cnt_q + CW'(1);
								end
							end
							CMD_LOAD_SECOND: begin
								if (second_full) begin
									dropped_q <= 1'b1;
								end else begin
									second_cnt_q <= second_cnt_q + CW'(1);
								end
							end
							CMD_ADD: begin
								i_q <= '0;
								j_q <= '0;
								if (first_cnt_q == '0 && second_cnt_q == '0) begin
									// nothing to merge: one empty result
									result_stb_q <= 1'b1;
									dropped_q    <= 1'b0;
								end else begin
									state_q <= ST_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					// memory read of both list heads lands this edge
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					result_stb_q <= 1'b1;
					i_q          <= i_next;
					j_q          <= j_next;
					if (step_last) begin
						first_cnt_q  <= '0;
						second_cnt_q <= '0;
						dropped_q    <= 1'b0;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			result_q.sum_coeff <= step_coeff;
			result_q.sum_power <= step_power;
			result_q.last_term <= step_last;
			result_q.empty_sum <= 1'b0;
			result_q.overflow  <= dropped_q;
		end else if (accept && item.cmd == CMD_ADD) begin
			result_q.sum_coeff <= '0;
			result_q.sum_power <= '0;
			result_q.last_term <= 1'b1;
			result_q.empty_sum <= 1'b1;
			result_q.overflow  <= dropped_q;
		end
	end

endmodule

`default_nettype wire
